/* sv/fpp_pkg.sv */
// shared constants, types and residue lookup for the fasta protein stream parser
`timescale 1ns / 1ps

package fpp_pkg;

    // default fixed width of the record name
    localparam int NAME_LEN_DEF = 10;

    // characters the parser reacts to
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;

    // residue code of the stop symbol
    localparam logic [4:0] CODE_STOP  = 5'd23;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_RESIDUE = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // line mode codes
    localparam logic [1:0] LM_NONE = 2'd0;
    localparam logic [1:0] LM_HDR  = 2'd1;
    localparam logic [1:0] LM_SEQ  = 2'd2;

    // work handed from the parser to the emitter for one request
    typedef struct packed {
        logic       hdr;
        logic       res;
        logic       rec_end;
        logic [4:0] code;
    } t_desc;

    // residue lookup result
    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_res;

    // map a byte onto its code in ARNDCQEGHILKMFPSTWYVBZX*
    function automatic t_res residue_lookup(input logic [7:0] b);
        t_res r;
        r.hit  = 1'b1;
        r.code = 5'd0;
        case (b)
            8'h41: r.code = 5'd0;   // A
            8'h52: r.code = 5'd1;   // R
            8'h4E: r.code = 5'd2;   // N
            8'h44: r.code = 5'd3;   // D
            8'h43: r.code = 5'd4;   // C
            8'h51: r.code = 5'd5;   // Q
            8'h45: r.code = 5'd6;   // E
            8'h47: r.code = 5'd7;   // G
            8'h48: r.code = 5'd8;   // H
            8'h49: r.code = 5'd9;   // I
            8'h4C: r.code = 5'd10;  // L
            8'h4B: r.code = 5'd11;  // K
            8'h4D: r.code = 5'd12;  // M
            8'h46: r.code = 5'd13;  // F
            8'h50: r.code = 5'd14;  // P
            8'h53: r.code = 5'd15;  // S
            8'h54: r.code = 5'd16;  // T
            8'h57: r.code = 5'd17;  // W
            8'h59: r.code = 5'd18;  // Y
            8'h56: r.code = 5'd19;  // V
            8'h42: r.code = 5'd20;  // B
            8'h5A: r.code = 5'd21;  // Z
            8'h58: r.code = 5'd22;  // X
            CHAR_STAR: r.code = CODE_STOP;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* sv/fpp_parse.sv */
// line and record tracking with the header name buffer
`timescale 1ns / 1ps

module fpp_parse #(
    parameter int NAME_LEN = fpp_pkg::NAME_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte_in,
    input  logic                  i_end_of_input,
    output fpp_pkg::t_desc        o_desc,
    output logic [NAME_LEN*8-1:0] o_name
);
    import fpp_pkg::*;

    localparam int CNT_W = $clog2(NAME_LEN + 1);
    localparam int IDX_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    logic [1:0]       r_mode, n_mode;
    logic             r_start, n_start;
    logic             r_open, n_open;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_hdr [NAME_LEN];
    logic             wr_en;
    t_res             res;
    t_desc            desc;

    assign res = residue_lookup(i_byte_in);

    // next state and the results this request causes
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_open  = r_open;
        n_count = r_count;
        wr_en   = 1'b0;
        desc    = '0;
        desc.code = res.code;
        if (i_end_of_input) begin
            desc.hdr     = !r_start && (r_mode == LM_HDR);
            desc.rec_end = r_open || desc.hdr;
            n_open  = 1'b0;
            n_mode  = LM_NONE;
            n_start = 1'b1;
            n_count = '0;
        end else if (r_start) begin
            if (i_byte_in == CHAR_GT) begin
                desc.rec_end = r_open;
                n_open  = 1'b0;
                n_mode  = LM_HDR;
                n_count = '0;
                n_start = 1'b0;
            end else if (i_byte_in == CHAR_NL) begin
                desc.rec_end = r_open;
                n_open = 1'b0;
                n_mode = LM_NONE;
            end else begin
                n_start = 1'b0;
                if (r_open) begin
                    n_mode   = LM_SEQ;
                    desc.res = res.hit;
                end else begin
                    n_mode = LM_NONE;
                end
            end
        end else if (i_byte_in == CHAR_NL) begin
            if (r_mode == LM_HDR) begin
                desc.hdr = 1'b1;
                n_open   = 1'b1;
            end
            n_mode  = LM_NONE;
            n_start = 1'b1;
        end else if (r_mode == LM_HDR) begin
            if (r_count < CNT_W'(NAME_LEN)) begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
            end
        end else if (r_mode == LM_SEQ) begin
            desc.res = res.hit;
        end
    end

    assign o_desc = desc;

    // name padded with spaces past the stored count
    always_comb begin
        for (int i = 0; i < NAME_LEN; i++) begin
            o_name[i*8 +: 8] = (CNT_W'(i) < r_count) ? r_hdr[i] : CHAR_SPACE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_NONE;
            r_start <= 1'b1;
            r_open  <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_open  <= n_open;
            r_count <= n_count;
        end
    end

    // header character store
    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_hdr[r_count[IDX_W-1:0]] <= i_byte_in;
        end
    end

endmodule

/* sv/fpp_emit.sv */
// serialises header, residue and record-end results into the output register
`timescale 1ns / 1ps

module fpp_emit #(
    parameter int NAME_LEN = fpp_pkg::NAME_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  fpp_pkg::t_desc        i_desc,
    input  logic [NAME_LEN*8-1:0] i_name,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_value,
    output logic [3:0]            o_header_pos,
    output logic                  o_last
);
    import fpp_pkg::*;

    localparam int IDX_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    // pending work
    logic                  r_hdr, n_hdr;
    logic                  r_res, n_res;
    logic                  r_end, n_end;
    logic [4:0]            r_code, n_code;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [NAME_LEN*8-1:0] r_name, n_name;

    // output register
    logic       r_ovalid, n_ovalid;
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_value, n_value;
    logic [3:0] r_pos, n_pos;
    logic       r_last, n_last;

    logic             out_free;
    logic             pend;
    logic             step;
    logic             hdr_done;
    logic             finish;
    logic [IDX_W+3:0] idx_ext;

    assign out_free = !r_ovalid || !i_stall;
    assign pend     = r_hdr || r_res || r_end;
    assign step     = out_free && pend;
    assign hdr_done = (r_idx == IDX_W'(NAME_LEN - 1));
    assign finish   = step && (r_res || (r_end && !r_hdr) || (r_hdr && hdr_done && !r_end));
    assign idx_ext  = {4'b0000, r_idx};

    assign o_can_load = !pend || finish;

    // pick the next result, then take a new request
    always_comb begin
        n_hdr    = r_hdr;
        n_res    = r_res;
        n_end    = r_end;
        n_code   = r_code;
        n_idx    = r_idx;
        n_name   = r_name;
        n_ovalid = r_ovalid && i_stall;
        n_kind   = r_kind;
        n_value  = r_value;
        n_pos    = r_pos;
        n_last   = r_last;
        if (step) begin
            n_ovalid = 1'b1;
            if (r_hdr) begin
                n_kind  = KIND_HEADER;
                n_value = r_name[7:0];
                n_pos   = idx_ext[3:0];
                n_last  = hdr_done && !r_end;
                n_name  = r_name >> 8;
                n_idx   = r_idx + 1'b1;
                if (hdr_done) begin
                    n_hdr = 1'b0;
                end
            end else if (r_res) begin
                n_kind  = KIND_RESIDUE;
                n_value = {3'b000, r_code};
                n_pos   = 4'd0;
                n_last  = 1'b1;
                n_res   = 1'b0;
            end else begin
                n_kind  = KIND_END;
                n_value = 8'd0;
                n_pos   = 4'd0;
                n_last  = 1'b1;
                n_end   = 1'b0;
            end
        end
        if (i_load) begin
            n_hdr  = i_desc.hdr;
            n_res  = i_desc.res;
            n_end  = i_desc.rec_end;
            n_code = i_desc.code;
            n_idx  = '0;
            n_name = i_name;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= 1'b0;
            r_res    <= 1'b0;
            r_end    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_hdr    <= n_hdr;
            r_res    <= n_res;
            r_end    <= n_end;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_idx   <= n_idx;
        r_name  <= n_name;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_last  <= n_last;
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_header_pos = r_pos;
    assign o_last       = r_last;

endmodule

/* sv/fasta_protein_stream_parser.sv */
// top level of the fasta protein stream parser
//
// Input channel: i_valid / o_stall carry one text byte (i_byte_in) or an
// end-of-stream mark (i_end_of_input) per request. Output channel:
// o_valid / i_stall carry one result per request: o_kind (header char,
// residue code, record end), o_value, o_header_pos and o_last, which flags
// the final result of one input request.
// A result passes the emitter's pending-work register, then the output
// register. Throughput: one byte per cycle for sequence and header
// characters unless i_stall holds the output. The newline that ends a
// header holds the input while the name is shifted out one character per
// result, plus a record end at end of stream in a header line.
// Reset (synchronous, active low) returns to line start outside any record
// and drops any result not yet taken. While i_stall is high the output
// register holds; the input is stalled once pending work cannot drain.
`timescale 1ns / 1ps

module fasta_protein_stream_parser #(
    parameter int NAME_LEN = fpp_pkg::NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic [3:0] o_header_pos,
    output logic       o_last
);
    import fpp_pkg::*;

    logic                  can_load;
    logic                  accept;
    t_desc                 desc;
    logic [NAME_LEN*8-1:0] name;

    assign o_stall = !can_load;
    assign accept  = i_valid && can_load;

    // line and record tracking
    fpp_parse #(
        .NAME_LEN (NAME_LEN)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte_in      (i_byte_in),
        .i_end_of_input (i_end_of_input),
        .o_desc         (desc),
        .o_name         (name)
    );

    // result serialiser and output register
    fpp_emit #(
        .NAME_LEN (NAME_LEN)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_desc       (desc),
        .i_name       (name),
        .o_can_load   (can_load),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_header_pos (o_header_pos),
        .o_last       (o_last)
    );

endmodule
